FILE: hw/rtl/lbbf_pkg.sv
package lbbf_pkg;

    localparam int LABEL_COUNT = 64;
    localparam int LABEL_W     = 6;
    localparam int COORD_W     = 10;
    localparam int CFG_W       = 11;
    localparam int PIXEL_W     = 24;
    localparam int QDEPTH      = 4;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // one classified pixel, front to back
    typedef struct packed {
        logic               hit;
        logic [LABEL_W-1:0] label;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               frame_end;
    } t_pix_entry;

    // stored box edges
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } t_box;

    // one emitted result
    typedef struct packed {
        logic               valid;
        logic [LABEL_W-1:0] label;
        logic               found;
        t_box               box;
        logic               last;
    } t_box_result;

endpackage

FILE: hw/rtl/lbbf_front.sv
module lbbf_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [lbbf_pkg::PIXEL_W-1:0] i_pixel_word,
    input  logic [lbbf_pkg::CFG_W-1:0]  i_image_width,
    input  logic [lbbf_pkg::CFG_W-1:0]  i_image_height,
    output logic                        o_push,
    output lbbf_pkg::t_pix_entry        o_entry
);

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int WW = (WB > lbbf_pkg::CFG_W) ? WB : lbbf_pkg::CFG_W;
    localparam int HW = (HB > lbbf_pkg::CFG_W) ? HB : lbbf_pkg::CFG_W;

    logic [lbbf_pkg::COORD_W-1:0] r_col, n_col;
    logic [lbbf_pkg::COORD_W-1:0] r_row, n_row;
    logic [WW-1:0]                w_eff;
    logic [HW-1:0]                h_eff;
    logic [WW-1:0]                w_cfg;
    logic [HW-1:0]                h_cfg;
    logic                         row_end;
    logic                         frame_end;
    logic [7:0]                   label_sum;

    // clamp frame size: zero acts as one, oversize acts as the maximum
    assign w_cfg = WW'(i_image_width);
    assign h_cfg = HW'(i_image_height);

    always_comb begin
        if (w_cfg == '0) begin
            w_eff = WW'(1);
        end else if (w_cfg > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end
        if (h_cfg == '0) begin
            h_eff = HW'(1);
        end else if (h_cfg > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = h_cfg;
        end
    end

    // detect row and frame end at the current position
    assign row_end   = (WW'(r_col) + WW'(1)) >= w_eff;
    assign frame_end = row_end && ((HW'(r_row) + HW'(1)) >= h_eff);

    // advance raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // classify the pixel into a label
    assign label_sum = {1'b0, i_pixel_word[15:12], 3'b000} + {4'b0000, i_pixel_word[7:4]};

    assign o_push             = i_accept;
    assign o_entry.hit        = (i_pixel_word[23:16] == 8'h00)
                                && (label_sum < 8'(lbbf_pkg::LABEL_COUNT));
    assign o_entry.label      = label_sum[lbbf_pkg::LABEL_W-1:0];
    assign o_entry.x          = r_col;
    assign o_entry.y          = r_row;
    assign o_entry.frame_end  = frame_end;

endmodule

FILE: hw/rtl/lbbf_fifo.sv
module lbbf_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lbbf_pkg::t_pix_entry i_entry,
    input  logic                 i_pop,
    output lbbf_pkg::t_pix_entry o_head,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int PTR_W = $clog2(lbbf_pkg::QDEPTH);

    lbbf_pkg::t_pix_entry r_mem [lbbf_pkg::QDEPTH];
    logic [PTR_W-1:0]     r_wptr;
    logic [PTR_W-1:0]     r_rptr;
    logic [PTR_W:0]       r_count;

    assign o_head  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_W+1)'(lbbf_pkg::QDEPTH));

    // store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // move pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/lbbf_back.sv
module lbbf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lbbf_pkg::t_pix_entry  i_head,
    input  logic                  i_empty,
    output logic                  o_pop,
    output lbbf_pkg::t_box_result o_result
);

    typedef enum logic {ST_RUN, ST_DUMP} t_state;

    t_state                       r_state;
    logic [lbbf_pkg::LABEL_W-1:0] r_k;
    logic [lbbf_pkg::LABEL_COUNT-1:0] r_seen;

    lbbf_pkg::t_box               r_mem [lbbf_pkg::LABEL_COUNT];
    lbbf_pkg::t_box               r_rdata;
    logic [lbbf_pkg::LABEL_W-1:0] rd_addr;

    logic                         r_b_valid;
    lbbf_pkg::t_pix_entry         r_b_entry;
    logic                         r_fwd_valid;
    logic [lbbf_pkg::LABEL_W-1:0] r_fwd_label;
    lbbf_pkg::t_box               r_fwd_data;

    logic                         r_d_valid;
    logic [lbbf_pkg::LABEL_W-1:0] r_d_k;
    lbbf_pkg::t_box_result        r_result;

    lbbf_pkg::t_box               b_old;
    lbbf_pkg::t_box               b_wdata;
    logic                         b_we;
    logic                         b_seen;
    logic                         d_found;

    // hold off the queue while dumping or while a frame end is in update
    assign o_pop   = (r_state == ST_RUN) && !i_empty && !(r_b_valid && r_b_entry.frame_end);
    assign rd_addr = (r_state == ST_DUMP) ? r_k : i_head.label;

    // box store: one write from update, one registered read
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_mem[r_b_entry.label] <= b_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // update: take back-to-back write on the same label, then widen the box
    assign b_we   = r_b_valid && r_b_entry.hit;
    assign b_seen = r_seen[r_b_entry.label];
    assign b_old  = (r_fwd_valid && (r_fwd_label == r_b_entry.label)) ? r_fwd_data : r_rdata;

    always_comb begin
        b_wdata = b_old;
        if (!b_seen) begin
            b_wdata.left   = r_b_entry.x;
            b_wdata.right  = r_b_entry.x;
            b_wdata.top    = r_b_entry.y;
            b_wdata.bottom = r_b_entry.y;
        end else begin
            if (r_b_entry.x < b_old.left) begin
                b_wdata.left = r_b_entry.x;
            end else if (r_b_entry.x > b_old.right) begin
                b_wdata.right = r_b_entry.x;
            end
            if (r_b_entry.y > b_old.bottom) begin
                b_wdata.bottom = r_b_entry.y;
            end
        end
    end

    assign d_found = r_seen[r_d_k];

    // sequencer, update stage, dump stage and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_RUN;
            r_k            <= '0;
            r_seen         <= '0;
            r_b_valid      <= 1'b0;
            r_fwd_valid    <= 1'b0;
            r_d_valid      <= 1'b0;
            r_result.valid <= 1'b0;
        end else begin
            r_b_valid   <= o_pop;
            if (o_pop) begin
                r_b_entry <= i_head;
            end
            r_fwd_valid <= b_we;
            r_fwd_label <= r_b_entry.label;
            r_fwd_data  <= b_wdata;
            if (b_we) begin
                r_seen[r_b_entry.label] <= 1'b1;
            end

            case (r_state)
                ST_RUN: begin
                    if (r_b_valid && r_b_entry.frame_end) begin
                        r_state <= ST_DUMP;
                        r_k     <= '0;
                    end
                end
                ST_DUMP: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == lbbf_pkg::LABEL_W'(lbbf_pkg::LABEL_COUNT - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase

            r_d_valid <= (r_state == ST_DUMP);
            r_d_k     <= r_k;

            // emit one box and drop its seen flag
            r_result.valid <= r_d_valid;
            if (r_d_valid) begin
                r_result.label <= r_d_k;
                r_result.found <= d_found;
                r_result.box   <= d_found ? r_rdata : '0;
                r_result.last  <= (r_d_k == lbbf_pkg::LABEL_W'(lbbf_pkg::LABEL_COUNT - 1));
                r_seen[r_d_k]  <= 1'b0;
            end
        end
    end

    assign o_result = r_result;

endmodule

FILE: hw/rtl/label_bounding_box_finder.sv
// Channel   Direction  Transfer condition              Payload
// pixel     in         start & !busy at clock edge     i_pixel_word
// result    out        o_valid, one cycle per box      o_label_index .. o_last_box
// config    in/out     psel & penable & pwrite         paddr, pwdata, prdata
//
// One pixel per cycle while busy is low; busy rises only when the 4-entry pixel
// queue is full, which happens while the back end dumps the 64 boxes.
// The last pixel of a frame causes 64 results on consecutive cycles, once it
// has passed the pixel queue and update register and the sequencer enters the
// dump, which walks the box store's registered read port one label per cycle.
// Reset (synchronous, active low) clears seen flags at once; no clearing pass.
// Results cannot be stalled by the receiver.
module label_bounding_box_finder #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lbbf_pkg::PIXEL_W-1:0]  i_pixel_word,
    output logic                          o_valid,
    output logic [lbbf_pkg::LABEL_W-1:0]  o_label_index,
    output logic                          o_found,
    output logic [lbbf_pkg::COORD_W-1:0]  o_box_left,
    output logic [lbbf_pkg::COORD_W-1:0]  o_box_top,
    output logic [lbbf_pkg::COORD_W-1:0]  o_box_right,
    output logic [lbbf_pkg::COORD_W-1:0]  o_box_bottom,
    output logic                          o_last_box,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lbbf_pkg::APB_AW-1:0]   paddr,
    input  logic [lbbf_pkg::APB_DW-1:0]   pwdata,
    output logic [lbbf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    logic [lbbf_pkg::CFG_W-1:0] r_image_width;
    logic [lbbf_pkg::CFG_W-1:0] r_image_height;
    logic                       accept;
    logic                       push;
    logic                       pop;
    logic                       q_empty;
    logic                       q_full;
    lbbf_pkg::t_pix_entry       push_entry;
    lbbf_pkg::t_pix_entry       head_entry;
    lbbf_pkg::t_box_result      result;

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= lbbf_pkg::CFG_W'(1024);
            r_image_height <= lbbf_pkg::CFG_W'(1024);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == lbbf_pkg::REG_IMAGE_WIDTH) begin
                r_image_width <= pwdata[lbbf_pkg::CFG_W-1:0];
            end else begin
                r_image_height <= pwdata[lbbf_pkg::CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == lbbf_pkg::REG_IMAGE_HEIGHT) begin
            prdata = lbbf_pkg::APB_DW'(r_image_height);
        end else begin
            prdata = lbbf_pkg::APB_DW'(r_image_width);
        end
    end

    // pixel transfer
    assign busy   = q_full;
    assign accept = start && !busy;

    lbbf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_pixel_word   (i_pixel_word),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    lbbf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    lbbf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_entry),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_result (result)
    );

    assign o_valid       = result.valid;
    assign o_label_index = result.label;
    assign o_found       = result.found;
    assign o_box_left    = result.box.left;
    assign o_box_top     = result.box.top;
    assign o_box_right   = result.box.right;
    assign o_box_bottom  = result.box.bottom;
    assign o_last_box    = result.last;

`ifndef SYNTHESIS
    // boxes of a frame come out on consecutive cycles in label order
    a_dump_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_box |=> o_valid
            && (o_label_index == lbbf_pkg::LABEL_W'($past(o_label_index) + 1'b1)))
        else $error("box dump out of order or interrupted");

    // nothing follows the last box directly
    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_box |=> !o_valid)
        else $error("result after last box");

    // a found box is well formed
    a_box_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> (o_box_left <= o_box_right) && (o_box_top <= o_box_bottom))
        else $error("malformed box");
`endif

endmodule

FILE: test/tb_label_bounding_box_finder.sv
`timescale 1ns / 1ps

module tb_label_bounding_box_finder;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int DUMP_SETTLE   = 16;
    localparam int STALL_LIMIT   = 3000;
    localparam int CHUNK_PIXELS  = 30;
    localparam int EDGE_PIXELS   = 24;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [lbbf_pkg::PIXEL_W-1:0]  i_pixel_word = '0;
    logic                          o_valid;
    logic [lbbf_pkg::LABEL_W-1:0]  o_label_index;
    logic                          o_found;
    logic [lbbf_pkg::COORD_W-1:0]  o_box_left;
    logic [lbbf_pkg::COORD_W-1:0]  o_box_top;
    logic [lbbf_pkg::COORD_W-1:0]  o_box_right;
    logic [lbbf_pkg::COORD_W-1:0]  o_box_bottom;
    logic                          o_last_box;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [lbbf_pkg::APB_AW-1:0]   paddr = '0;
    logic [lbbf_pkg::APB_DW-1:0]   pwdata = '0;
    logic [lbbf_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    // pixel stream waiting for transfer, and box reports owed by the block
    logic [lbbf_pkg::PIXEL_W-1:0]  pixels_to_send [$];
    lbbf_pkg::t_box_result         box_reports_due [$];
    lbbf_pkg::t_box_result         report_head;
    int                            pixels_pushed = 0;
    int                            pixels_taken = 0;
    int                            send_idle_pct = 0;
    int                            mismatches = 0;
    int                            stall_cycles = 0;

    // shadow of the block state
    logic [lbbf_pkg::CFG_W-1:0]    width_reg = lbbf_pkg::CFG_W'(1024);
    logic [lbbf_pkg::CFG_W-1:0]    height_reg = lbbf_pkg::CFG_W'(1024);
    logic                          box_seen [lbbf_pkg::LABEL_COUNT];
    lbbf_pkg::t_box                box_edges [lbbf_pkg::LABEL_COUNT];
    logic [lbbf_pkg::COORD_W-1:0]  scan_col = '0;
    logic [lbbf_pkg::COORD_W-1:0]  scan_row = '0;

    label_bounding_box_finder #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_pixel_word  (i_pixel_word),
        .o_valid       (o_valid),
        .o_label_index (o_label_index),
        .o_found       (o_found),
        .o_box_left    (o_box_left),
        .o_box_top     (o_box_top),
        .o_box_right   (o_box_right),
        .o_box_bottom  (o_box_bottom),
        .o_last_box    (o_last_box),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // a zero size acts as one, an oversize acts as the maximum
    function automatic int frame_dim(input logic [lbbf_pkg::CFG_W-1:0] v, input int maxv);
        if (v == '0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    // grow the box of one pixel's label, advance the raster position,
    // and owe all 64 boxes when the frame closes
    task automatic track_pixel(input logic [lbbf_pkg::PIXEL_W-1:0] pix);
        int                     lbl;
        int                     w;
        int                     h;
        logic                   row_end;
        logic                   frame_end;
        lbbf_pkg::t_box_result  rep;
        w = frame_dim(width_reg, MAX_W);
        h = frame_dim(height_reg, MAX_H);
        lbl = int'(pix[7:4]) + 8 * int'(pix[15:12]);
        if (pix[23:16] == 8'h00 && lbl < lbbf_pkg::LABEL_COUNT) begin
            if (!box_seen[lbl]) begin
                box_edges[lbl] = '{left: scan_col, top: scan_row,
                                   right: scan_col, bottom: scan_row};
                box_seen[lbl] = 1'b1;
            end else begin
                if (scan_col < box_edges[lbl].left) begin
                    box_edges[lbl].left = scan_col;
                end else if (scan_col > box_edges[lbl].right) begin
                    box_edges[lbl].right = scan_col;
                end
                if (scan_row > box_edges[lbl].bottom) begin
                    box_edges[lbl].bottom = scan_row;
                end
            end
        end
        row_end = (int'(scan_col) + 1 >= w);
        frame_end = row_end && (int'(scan_row) + 1 >= h);
        if (row_end) begin
            scan_col = '0;
            scan_row = frame_end ? '0 : scan_row + 1'b1;
        end else begin
            scan_col = scan_col + 1'b1;
        end
        if (frame_end) begin
            for (int k = 0; k < lbbf_pkg::LABEL_COUNT; k++) begin
                rep.valid = 1'b1;
                rep.label = lbbf_pkg::LABEL_W'(k);
                rep.found = box_seen[k];
                rep.box = box_seen[k] ? box_edges[k] : '0;
                rep.last = (k == lbbf_pkg::LABEL_COUNT - 1);
                box_reports_due.insert(box_reports_due.size(), rep);
                box_seen[k] = 1'b0;
                box_edges[k] = '0;
            end
        end
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // mostly labels that hit the store, a few ignored or skipped pixels
    function automatic logic [lbbf_pkg::PIXEL_W-1:0] make_pixel();
        int         pick;
        logic [3:0] grp;
        logic [3:0] bits;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            grp = 4'h0;
            bits = 4'($urandom_range(0, 3));
        end else if (pick < 75) begin
            grp = 4'($urandom_range(0, 7));
            bits = (grp == 4'h7) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(0, 15));
        end else if (pick < 85) begin
            grp = 4'($urandom_range(7, 15));
            bits = (grp == 4'h7) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 15));
        end else if (pick < 95) begin
            return {8'($urandom_range(1, 255)), 16'($urandom)};
        end else begin
            return 24'hFFFFFF;
        end
        return {8'h00, grp, 4'($urandom), bits, 4'($urandom)};
    endfunction

    task automatic push_pixel(input logic [lbbf_pkg::PIXEL_W-1:0] pix);
        pixels_to_send.insert(pixels_to_send.size(), pix);
        pixels_pushed++;
    endtask

    task automatic push_random(input int count);
        repeat (count) push_pixel(make_pixel());
    endtask

    // hold off until every pixel has transferred and every box has come out
    task automatic settle();
        while (pixels_taken != pixels_pushed || box_reports_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DUMP_SETTLE) @(posedge i_clk);
    endtask

    // setup cycle, then access cycle; the register takes the value at its end,
    // then read it back the same way
    task automatic write_reg(input logic idx, input logic [lbbf_pkg::APB_DW-1:0] value);
        string                      reg_name;
        logic [lbbf_pkg::CFG_W-1:0] want;
        reg_name = (idx == lbbf_pkg::REG_IMAGE_WIDTH) ? "image_width" : "image_height";
        want = value[lbbf_pkg::CFG_W-1:0];
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == lbbf_pkg::REG_IMAGE_WIDTH) begin
            width_reg = want;
        end else begin
            height_reg = want;
        end
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_field(reg_name, want, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // pixel driver: hold an offer until it transfers, otherwise offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                track_pixel(i_pixel_word);
                pixels_taken++;
            end
            if (!(start && busy)) begin
                if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    start <= 1'b1;
                    i_pixel_word <= pixels_to_send[0];
                    pixels_to_send.delete(0);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor: every strobe is a transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (box_reports_due.size() == 0) begin
                $error("unexpected box result for label %0d", o_label_index);
                mismatches++;
            end else begin
                report_head = box_reports_due[0];
                box_reports_due.delete(0);
                check_field("label_index", report_head.label, o_label_index);
                check_field("found", report_head.found, o_found);
                check_field("box_left", report_head.box.left, o_box_left);
                check_field("box_top", report_head.box.top, o_box_top);
                check_field("box_right", report_head.box.right, o_box_right);
                check_field("box_bottom", report_head.box.bottom, o_box_bottom);
                check_field("last_box", report_head.last, o_last_box);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        foreach (box_seen[k]) begin
            box_seen[k] = 1'b0;
            box_edges[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size: label 0, all-ones skip, label 63, high label ignored
        send_idle_pct = 0;
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h007777);
        push_pixel(24'h00FFFF);
        settle();

        // zero width acts as one; size change lands past the current column
        write_reg(lbbf_pkg::REG_IMAGE_WIDTH, 32'd0);
        write_reg(lbbf_pkg::REG_IMAGE_HEIGHT, 32'd2);
        push_pixel(24'h000F0F);
        push_pixel(24'hFF0000);
        settle();

        // upper data bits dropped; height 0x800 masks to zero
        write_reg(lbbf_pkg::REG_IMAGE_WIDTH, 32'hFFFF_F803);
        write_reg(lbbf_pkg::REG_IMAGE_HEIGHT, 32'h0000_0800);
        write_reg(lbbf_pkg::REG_IMAGE_HEIGHT, 32'h0000_0802);
        push_pixel(24'h807050);
        push_pixel(24'h00005A);
        push_pixel(24'h0070F0);
        push_pixel(24'h000F53);
        push_pixel(24'h007000);
        push_pixel(24'h000050);
        settle();

        // oversize width keeps the row open, then a narrower width closes it
        write_reg(lbbf_pkg::REG_IMAGE_WIDTH, 32'd2047);
        write_reg(lbbf_pkg::REG_IMAGE_HEIGHT, 32'd1);
        push_pixel(24'h000010);
        push_random(EDGE_PIXELS - 2);
        push_pixel(24'h00001F);
        settle();
        write_reg(lbbf_pkg::REG_IMAGE_WIDTH, 32'd20);
        push_pixel(24'h000012);
        settle();

        // oversize height keeps the frame open, sender mostly idle
        send_idle_pct = 69;
        write_reg(lbbf_pkg::REG_IMAGE_WIDTH, 32'd1);
        write_reg(lbbf_pkg::REG_IMAGE_HEIGHT, 32'd2047);
        push_pixel(24'h000020);
        push_random(EDGE_PIXELS + 4);
        push_pixel(24'h000A2B);
        settle();
        write_reg(lbbf_pkg::REG_IMAGE_HEIGHT, 32'd8);
        push_pixel(24'h000A20);
        settle();

        // small random frames under each sender idle mix
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 0 : (ph == 1) ? 69 : 16;
            repeat (2) begin
                write_reg(lbbf_pkg::REG_IMAGE_WIDTH,
                          ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 8)));
                write_reg(lbbf_pkg::REG_IMAGE_HEIGHT,
                          ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 5)));
                push_random(CHUNK_PIXELS);
                settle();
            end
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
